[hdl/heading_twist_controller_macros.svh]
// Assertion macros for the heading twist controller.
`ifndef HEADING_TWIST_CONTROLLER_MACROS_SVH
`define HEADING_TWIST_CONTROLLER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define HTC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define HTC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/htc_pkg.sv]
// Shared types and constants of the heading twist controller.
package htc_pkg;

   localparam int AngleW    = 32;
   localparam int TimeW     = 32;
   localparam int SpeedW    = 7;
   localparam int LimitW    = 16;
   localparam int CsrIndexW = 3;
   localparam int CsrDataW  = 16;

   // Wrapped angle: 9-bit degrees above 8 fraction bits, 0 .. 92159.
   localparam int FracW     = 8;
   localparam int DegW      = 9;
   localparam int WrapW     = DegW + FracW;
   localparam int DeltaW    = WrapW + 1;
   localparam int Deg360    = 360;
   localparam int FullTurn  = Deg360 << FracW;

   localparam logic [SpeedW-1:0] TwistSpeedRst = 7'd50;
   localparam logic [LimitW-1:0] CoarseThrRst  = 16'd1280;
   localparam logic [SpeedW-1:0] BrakeSpeedRst = 7'd10;
   localparam logic [SpeedW-1:0] FineSpeedRst  = 7'd20;
   localparam logic [LimitW-1:0] SettleMsRst   = 16'd50;
   localparam logic [LimitW-1:0] FineTolRst    = 16'd256;

   typedef enum logic [CsrIndexW-1:0] {
      CSR_TWIST_SPEED      = 3'd0,
      CSR_COARSE_THRESHOLD = 3'd1,
      CSR_BRAKE_SPEED      = 3'd2,
      CSR_FINE_SPEED       = 3'd3,
      CSR_SETTLE_MS        = 3'd4,
      CSR_FINE_TOLERANCE   = 3'd5
   } htc_csr_type;

   typedef enum logic {
      CMD_START = 1'b0,
      CMD_TICK  = 1'b1
   } htc_cmd_type;

   typedef enum logic [1:0] {
      MODE_CCW     = 2'd0,
      MODE_CW      = 2'd1,
      MODE_SHORTER = 2'd2
   } htc_mode_type;

   typedef struct packed {
      logic                    command;
      logic signed [AngleW-1:0] heading;
      logic signed [AngleW-1:0] target_heading;
      logic [1:0]              turn_mode;
      logic [TimeW-1:0]        now_ms;
   } htc_req_type;

   typedef struct packed {
      logic              drive_update;
      logic              left_reverse;
      logic [SpeedW-1:0] left_speed;
      logic              right_reverse;
      logic [SpeedW-1:0] right_speed;
      logic              motors_stop;
      logic              busy_res;
   } htc_rsp_type;

endpackage

[hdl/htc_if.sv]
// Valid/ready channel interfaces for the request and response transactions.
interface htc_req_if;
   import htc_pkg::*;
   logic        valid;
   logic        ready;
   htc_req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface htc_rsp_if;
   import htc_pkg::*;
   logic        valid;
   logic        ready;
   htc_rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[hdl/htc_wrap.sv]
// Wraps a signed fixed-point angle into [0, 360) degrees.
module htc_wrap (
   input  logic signed [htc_pkg::AngleW-1:0] angle,
   output logic [htc_pkg::WrapW-1:0]         wrapped
);
   import htc_pkg::*;

   // Whole degrees split into a signed top byte and two unsigned bytes;
   // the top and middle bytes' weights reduced mod 360 by constant tables.
   logic [DegW-1:0]   hi_res [256];
   logic [DegW-1:0]   mid_res [256];
   logic [7:0]        hi_byte;
   logic [7:0]        mid_byte;
   logic [7:0]        lo_byte;
   logic [DegW+1:0]   res_sum;
   logic [DegW-1:0]   deg;

   for (genvar g = 0; g < 256; g++) begin : g_res
      localparam int SByte  = (g < 128) ? g : g - 256;
      localparam int HiRes  = (((SByte * 65536) % Deg360) + Deg360) % Deg360;
      localparam int MidRes = (g * 256) % Deg360;
      assign hi_res[g]  = DegW'(HiRes);
      assign mid_res[g] = DegW'(MidRes);
   end

   assign hi_byte  = angle[31:24];
   assign mid_byte = angle[23:16];
   assign lo_byte  = angle[15:8];

   always_comb begin
      res_sum = (DegW+2)'(hi_res[hi_byte]) + (DegW+2)'(mid_res[mid_byte])
              + (DegW+2)'(lo_byte);
      if (res_sum >= (DegW+2)'(2 * Deg360)) begin
         deg = DegW'(res_sum - (DegW+2)'(2 * Deg360));
      end else if (res_sum >= (DegW+2)'(Deg360)) begin
         deg = DegW'(res_sum - (DegW+2)'(Deg360));
      end else begin
         deg = DegW'(res_sum);
      end
   end

   assign wrapped = {deg, angle[FracW-1:0]};

endmodule

[hdl/heading_twist_controller.sv]
// Top level of the in-place heading twist controller.
//
//  channel   dir  handshake     payload
//  req_chan  in   valid/ready   command, heading, target_heading, turn_mode, now_ms
//  rsp_chan  out  valid/ready   drive_update, speeds, directions, motors_stop, busy_res
//  csr_*     in   csr_we        csr_index, csr_wdata (write only)
//
// One transaction per cycle sustained while the output is not stalled. Three
// register stages: input register, wrapped-angle register (two mod-360 table
// reductions), result register. Turn state updates as a result enters the
// output register. Reset is synchronous: it empties the pipeline, clears the
// turn state and loads register defaults. A stalled output backs ready up stage
// by stage, so up to three transactions are held.
`include "heading_twist_controller_macros.svh"

module heading_twist_controller (
   input  logic                          clock,
   input  logic                          reset,
   htc_req_if.sink                       req_chan,
   htc_rsp_if.source                     rsp_chan,
   input  logic                          csr_we,
   input  logic [htc_pkg::CsrIndexW-1:0] csr_index,
   input  logic [htc_pkg::CsrDataW-1:0]  csr_wdata
);
   import htc_pkg::*;

   // configuration
   logic [SpeedW-1:0] twist_speed_ff;
   logic [LimitW-1:0] coarse_thr_ff;
   logic [SpeedW-1:0] brake_speed_ff;
   logic [SpeedW-1:0] fine_speed_ff;
   logic [LimitW-1:0] settle_ms_ff;
   logic [LimitW-1:0] fine_tol_ff;

   // pipeline
   logic             s1_valid_ff, s1_valid_in;
   htc_req_type      s1_data_ff;
   logic             s2_valid_ff, s2_valid_in;
   htc_req_type      s2_data_ff;
   logic [WrapW-1:0] s2_target_ff;
   logic [WrapW-1:0] s2_head_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   htc_rsp_type      rsp_data_ff, rsp_data_in;
   logic             s1_free, s2_free, rsp_load;
   logic [WrapW-1:0] target_wrap, head_wrap;

   // turn state
   logic [AngleW-1:0] goal_ff, goal_in;
   logic              pos_turn_ff, pos_turn_in;
   logic              neg_turn_ff, neg_turn_in;
   logic              turning_ff, turning_in;
   logic              braked_ff, braked_in;
   logic [TimeW-1:0]  brake_time_ff, brake_time_in;

   // start decision
   logic signed [DeltaW-1:0] d1;
   logic [WrapW-1:0]         abs_d1;
   logic [WrapW-1:0]         d2;
   logic signed [DeltaW-1:0] ccw, cw, delta;
   logic [WrapW-1:0]         abs_ccw, abs_cw;

   // tick decision
   logic [AngleW-1:0]        err;
   logic signed [AngleW:0]   err_x;
   logic signed [AngleW:0]   thr_x, tol_x;
   logic                     err_pos;
   logic [TimeW-1:0]         elapsed;

   function automatic htc_rsp_type drive_cmd(logic ccw_spin, logic [SpeedW-1:0] spd);
      htc_rsp_type r;
      r = '0;
      r.drive_update  = 1'b1;
      r.left_reverse  = ccw_spin;
      r.left_speed    = spd;
      r.right_reverse = !ccw_spin;
      r.right_speed   = spd;
      return r;
   endfunction

   // ---------------- configuration writes ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         twist_speed_ff <= TwistSpeedRst;
         coarse_thr_ff  <= CoarseThrRst;
         brake_speed_ff <= BrakeSpeedRst;
         fine_speed_ff  <= FineSpeedRst;
         settle_ms_ff   <= SettleMsRst;
         fine_tol_ff    <= FineTolRst;
      end else if (csr_we) begin
         case (htc_csr_type'(csr_index))
            CSR_TWIST_SPEED:      twist_speed_ff <= csr_wdata[SpeedW-1:0];
            CSR_COARSE_THRESHOLD: coarse_thr_ff  <= csr_wdata;
            CSR_BRAKE_SPEED:      brake_speed_ff <= csr_wdata[SpeedW-1:0];
            CSR_FINE_SPEED:       fine_speed_ff  <= csr_wdata[SpeedW-1:0];
            CSR_SETTLE_MS:        settle_ms_ff   <= csr_wdata;
            CSR_FINE_TOLERANCE:   fine_tol_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- pipeline flow ----------------
   assign rsp_load = s2_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign s2_free  = !s2_valid_ff || rsp_load;
   assign s1_free  = !s1_valid_ff || s2_free;

   assign req_chan.ready  = s1_free;
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   always_comb begin
      s1_valid_in  = s1_free ? req_chan.valid : s1_valid_ff;
      s2_valid_in  = s2_free ? s1_valid_ff : s2_valid_ff;
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   htc_wrap u_wrap_target (
      .angle   (s1_data_ff.target_heading),
      .wrapped (target_wrap)
   );

   htc_wrap u_wrap_head (
      .angle   (s1_data_ff.heading),
      .wrapped (head_wrap)
   );

   always_ff @(posedge clock) begin
      if (s1_free) begin
         s1_data_ff <= req_chan.payload;
      end
      if (s2_free) begin
         s2_data_ff   <= s1_data_ff;
         s2_target_ff <= target_wrap;
         s2_head_ff   <= head_wrap;
      end
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // ---------------- start: pick the turn ----------------
   always_comb begin
      d1     = $signed({1'b0, s2_target_ff}) - $signed({1'b0, s2_head_ff});
      abs_d1 = d1[DeltaW-1] ? WrapW'(-d1) : WrapW'(d1);
      d2     = WrapW'(FullTurn) - abs_d1;
      if (d1 > 0) begin
         ccw     = d1;
         cw      = -$signed({1'b0, d2});
         abs_ccw = abs_d1;
         abs_cw  = d2;
      end else begin
         ccw     = $signed({1'b0, d2});
         cw      = d1;
         abs_ccw = d2;
         abs_cw  = abs_d1;
      end
      case (htc_mode_type'(s2_data_ff.turn_mode))
         MODE_CCW: delta = ccw;
         MODE_CW:  delta = cw;
         default:  delta = (abs_ccw < abs_cw) ? ccw : cw;
      endcase
   end

   // ---------------- tick: error and timer ----------------
   always_comb begin
      err     = goal_ff - s2_data_ff.heading;
      err_x   = $signed({err[AngleW-1], err});
      err_pos = !err[AngleW-1] && (err != '0);
      thr_x   = $signed({{(AngleW+1-LimitW){1'b0}}, coarse_thr_ff});
      tol_x   = $signed({{(AngleW+1-LimitW){1'b0}}, fine_tol_ff});
      elapsed = s2_data_ff.now_ms - brake_time_ff;
   end

   // ---------------- next state and result ----------------
   always_comb begin
      rsp_data_in   = '0;
      goal_in       = goal_ff;
      pos_turn_in   = pos_turn_ff;
      neg_turn_in   = neg_turn_ff;
      turning_in    = turning_ff;
      braked_in     = braked_ff;
      brake_time_in = brake_time_ff;
      if (s2_data_ff.command == CMD_START) begin
         goal_in     = s2_data_ff.heading + {{(AngleW-DeltaW){delta[DeltaW-1]}}, delta};
         pos_turn_in = !delta[DeltaW-1] && (delta != '0);
         neg_turn_in = delta[DeltaW-1];
         turning_in  = 1'b1;
         braked_in   = 1'b0;
      end else if (turning_ff) begin
         if (!braked_ff) begin
            if ((pos_turn_ff && (err_x > thr_x)) || (neg_turn_ff && (err_x < -thr_x))) begin
               rsp_data_in = drive_cmd(err_pos, twist_speed_ff);
            end else begin
               // coarse phase over: reverse pulse against the turn direction
               braked_in     = 1'b1;
               brake_time_in = s2_data_ff.now_ms;
               rsp_data_in   = drive_cmd(!pos_turn_ff, brake_speed_ff);
            end
         end else if (elapsed > {{(TimeW-LimitW){1'b0}}, settle_ms_ff}) begin
            if (err_x > tol_x) begin
               rsp_data_in = drive_cmd(1'b1, fine_speed_ff);
            end else if (err_x < -tol_x) begin
               rsp_data_in = drive_cmd(1'b0, fine_speed_ff);
            end else begin
               turning_in               = 1'b0;
               rsp_data_in.drive_update = 1'b1;
               rsp_data_in.motors_stop  = 1'b1;
            end
         end
      end
      rsp_data_in.busy_res = turning_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_ff       <= '0;
         pos_turn_ff   <= 1'b0;
         neg_turn_ff   <= 1'b0;
         turning_ff    <= 1'b0;
         braked_ff     <= 1'b0;
         brake_time_ff <= '0;
      end else if (rsp_load) begin
         goal_ff       <= goal_in;
         pos_turn_ff   <= pos_turn_in;
         neg_turn_ff   <= neg_turn_in;
         turning_ff    <= turning_in;
         braked_ff     <= braked_in;
         brake_time_ff <= brake_time_in;
      end
   end

   // ---------------- assertions ----------------
   `HTC_ASSERT_NOW(a_busy_tracks_state, clock, reset, rsp_valid_ff, rsp_data_ff.busy_res == turning_ff, "busy_res disagrees with turn state")
   `HTC_ASSERT_NOW(a_stop_ends_turn, clock, reset, rsp_valid_ff && rsp_data_ff.motors_stop, rsp_data_ff.drive_update && !rsp_data_ff.busy_res && rsp_data_ff.left_speed == '0 && rsp_data_ff.right_speed == '0, "stop transaction malformed")
   `HTC_ASSERT_NOW(a_brake_while_turning, clock, reset, $rose(braked_ff), turning_ff && rsp_valid_ff && rsp_data_ff.drive_update, "brake set outside a turn")
   `HTC_ASSERT_NEXT(a_no_result_without_item, clock, reset, !s2_valid_ff && !rsp_valid_ff, !rsp_valid_ff, "result appeared with empty pipeline")

endmodule
